// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg: shared definitions for the bounded deque
// Operation and status codes, stream field widths, and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_LIST       = 3'd4
   } op_type;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic exec_op;
      logic list_empty;
      logic idx_clear;
      logic rd_en;
      logic emit_entry;
      logic idx_inc;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic idx_last;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/bounded_deque_with_listing.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_listing: bounded double-ended queue with listing
// A ring store of DEPTH signed 32-bit entries with push and pop at both
// ends and a front-to-back listing of all entries.
//
// Usage: each request on the req_ stream carries an op and a value. Push
// and pop requests each give one response with a status and tlast set.
// A list request gives one response per entry, front to back, with tlast
// on the final one, or a single empty-status response on an empty queue.
// Unused op codes are consumed without a response.
// A push or pop response is registered and shows in the cycle after the
// request is accepted. A listing reads each entry into the store's read
// register, then sends it out; no request is accepted while it runs.
// Throughput: one push or pop request per cycle while responses are taken.
// Reset empties the queue; the store itself is not cleared.
// When the receiver stalls, the response register holds and new requests
// wait in req_tready low until the response register can be loaded.
// ----------------------------------------------------------------------------
module bounded_deque_with_listing
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // op [2:0], value [34:3], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // item [31:0], status [33:32], zero pad
   output logic                   rsp_tlast
);

   cmd_type             cmd;
   stat_type            stat;
   logic [OP_W-1:0]     req_op;
   logic [VALUE_W-1:0]  req_value;
   logic [VALUE_W-1:0]  rsp_item;
   logic [STATUS_W-1:0] rsp_status;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_value = req_tdata[OP_W+VALUE_W-1:OP_W];
   assign rsp_tdata = {{(RSP_TDATA_W-VALUE_W-STATUS_W){1'b0}}, rsp_status, rsp_item};

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

endmodule

// ===== rtl/core/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl: deque controller
// Accepts requests, sequences push and pop updates and walks the entries
// one at a time during a listing.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [OP_W-1:0] req_op,
   input  stat_type        stat,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_LREAD = 3'b010,
      S_LSEND = 3'b100
   } state_type;

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               if (op inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK}) begin
                  cmd.exec_op = 1'b1;
               end else if (op == OP_LIST) begin
                  if (stat.empty) begin
                     cmd.list_empty = 1'b1;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_LREAD;
                  end
               end
            end
         end
         S_LREAD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LSEND;
         end
         S_LSEND: begin
            if (stat.out_free) begin
               cmd.emit_entry = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_LREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/bdq_dpath.sv =====
// ----------------------------------------------------------------------------
// bdq_dpath: deque datapath
// Holds the ring store, the front index, the entry count, the listing
// index and the response register.
// ----------------------------------------------------------------------------
module bdq_dpath
   import bdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_op,
   input  logic [VALUE_W-1:0]  req_value,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_item,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   logic [VALUE_W-1:0]  mem [DEPTH];
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic                out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]  item_ff, item_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                last_ff, last_in;

   logic             full, empty, load;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr, front_dec, front_inc, back_pos;
   logic [SUM_W-1:0] back_sum, rd_sum;
   op_type           op;

   assign op    = op_type'(req_op);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   assign back_sum = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_pos = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);
   assign rd_sum   = SUM_W'(front_ff) + SUM_W'(idx_ff);
   assign rd_addr  = (rd_sum >= SUM_W'(DEPTH)) ? IDX_W'(rd_sum - SUM_W'(DEPTH))
                                               : IDX_W'(rd_sum);

   assign stat.empty    = empty;
   assign stat.idx_last = ((CNT_W'(idx_ff) + 1'b1) == count_ff);
   assign stat.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = back_pos;
      load      = 1'b0;
      item_in   = item_ff;
      status_in = status_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      if (cmd.exec_op) begin
         load      = 1'b1;
         item_in   = '0;
         last_in   = 1'b1;
         status_in = ST_OK;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (op == OP_PUSH_FRONT) begin
                     wr_addr  = front_dec;
                     front_in = front_dec;
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  if (op == OP_POP_FRONT) begin
                     front_in = front_inc;
                  end
               end
            end
            default: begin
               load = 1'b0;
            end
         endcase
      end
      if (cmd.list_empty) begin
         load      = 1'b1;
         item_in   = '0;
         status_in = ST_EMPTY;
         last_in   = 1'b1;
      end
      if (cmd.emit_entry) begin
         load      = 1'b1;
         item_in   = rd_data_ff;
         status_in = ST_OK;
         last_in   = stat.idx_last;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      item_ff   <= item_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_item   = item_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule
